// ----- rtl/core/paged_bitmap_slot_allocator_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the paged bitmap slot allocator
// Implication and next-cycle implication checks, compiled out when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef PAGED_BITMAP_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define PAGED_BITMAP_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTH
`define PBSA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pbsa: same-cycle check failed");
`define PBSA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pbsa: next-cycle check failed");
`else
`define PBSA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PBSA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/pbsa_pkg.sv -----
// ----------------------------------------------------------------------------
// pbsa_pkg
// Shared widths, codes, the reciprocal table and helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pbsa_pkg;

   localparam int IDX_W       = 11;
   localparam int UPP_W       = 6;
   localparam int UPP_MAX     = 32;
   localparam int LOC_MAX_W   = 5;
   localparam int QUO_W       = 11;
   localparam int TOTAL_W     = 12;
   localparam int PGOUT_W     = 7;
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 17;

   localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OCCUPY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FREE   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   // Page number and position inside the page of a global slot index.
   typedef struct packed {
      logic [QUO_W-1:0]     page;
      logic [LOC_MAX_W-1:0] loc;
   } div_res_type;

   // ceil(2^17 / d): exact floor quotient for any 11-bit dividend and d up to 32.
   function automatic logic [RECIP_W-1:0] recip_of(input logic [UPP_W-1:0] d);
      logic [RECIP_W-1:0] r;
      case (d)
         6'd1:    r = 18'd131072;
         6'd2:    r = 18'd65536;
         6'd3:    r = 18'd43691;
         6'd4:    r = 18'd32768;
         6'd5:    r = 18'd26215;
         6'd6:    r = 18'd21846;
         6'd7:    r = 18'd18725;
         6'd8:    r = 18'd16384;
         6'd9:    r = 18'd14564;
         6'd10:   r = 18'd13108;
         6'd11:   r = 18'd11916;
         6'd12:   r = 18'd10923;
         6'd13:   r = 18'd10083;
         6'd14:   r = 18'd9363;
         6'd15:   r = 18'd8739;
         6'd16:   r = 18'd8192;
         6'd17:   r = 18'd7711;
         6'd18:   r = 18'd7282;
         6'd19:   r = 18'd6899;
         6'd20:   r = 18'd6554;
         6'd21:   r = 18'd6242;
         6'd22:   r = 18'd5958;
         6'd23:   r = 18'd5699;
         6'd24:   r = 18'd5462;
         6'd25:   r = 18'd5243;
         6'd26:   r = 18'd5042;
         6'd27:   r = 18'd4855;
         6'd28:   r = 18'd4682;
         6'd29:   r = 18'd4520;
         6'd30:   r = 18'd4370;
         6'd31:   r = 18'd4229;
         6'd32:   r = 18'd4096;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Ones in every bit position below the page size.
   function automatic logic [UPP_MAX-1:0] upp_mask(input logic [UPP_W-1:0] upp);
      logic [UPP_MAX-1:0] m;
      for (int i = 0; i < UPP_MAX; i++) begin
         m[i] = (UPP_W'(i) < upp);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/paged_bitmap_slot_allocator_core.sv -----
// ----------------------------------------------------------------------------
// paged_bitmap_slot_allocator_core: paged first-fit slot allocator
// Each request passes the index split and page search, the bitmap read and the
// update in turn; a new request is taken only once the block is back in idle.
// Reset: a sweep zeroes all MAX_PAGES words of the bitmap memory; no request
// is taken during the sweep, register writes are.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "paged_bitmap_slot_allocator_core_assert.svh"

module paged_bitmap_slot_allocator_core #(
   parameter int MAX_PAGES          = 64,
   parameter int MAX_UNITS_PER_PAGE = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [10:0] unit_index, [15:11] zero
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [10:0] slot_index, [11] allocated,
                                    // [23:12] total_used, [30:24] pages_in_use,
                                    // [31] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // Page size register write.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_data     // [5:0] units_per_page
);

   localparam int IDX_W    = pbsa_pkg::IDX_W;
   localparam int UPP_W    = pbsa_pkg::UPP_W;
   localparam int TOTAL_W  = pbsa_pkg::TOTAL_W;
   localparam int PGOUT_W  = pbsa_pkg::PGOUT_W;
   localparam int KIND_W   = pbsa_pkg::KIND_W;
   localparam int STATUS_W = pbsa_pkg::STATUS_W;
   localparam int UPP_MAX  = pbsa_pkg::UPP_MAX;
   localparam int PAGE_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int PCNT_W   = $clog2(MAX_PAGES + 1);
   localparam int LOC_W    = (MAX_UNITS_PER_PAGE > 1) ? $clog2(MAX_UNITS_PER_PAGE) : 1;
   localparam int BM_W     = MAX_UNITS_PER_PAGE;

   // Sequencer states.
   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_CLEAR = 3'd0;  // zero the bitmap memory
   localparam logic [ST_W-1:0] ST_IDLE  = 3'd1;  // wait for a request
   localparam logic [ST_W-1:0] ST_CALC  = 3'd2;  // divider and search, first stage
   localparam logic [ST_W-1:0] ST_SEL   = 3'd3;  // divider and search, second stage
   localparam logic [ST_W-1:0] ST_READ  = 3'd4;  // pick the page, read its bitmap
   localparam logic [ST_W-1:0] ST_MOD   = 3'd5;  // update, write back, respond

   // Control state.
   logic [ST_W-1:0]     state_ff, state_in;
   logic [PAGE_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [UPP_W-1:0]    upp_ff, upp_in;
   logic [PCNT_W-1:0]   page_count_ff, page_count_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [MAX_PAGES-1:0] full_ff, full_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Item in flight.
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [PAGE_W-1:0]   tgt_ff, tgt_in;
   logic [LOC_W-1:0]    loc_ff, loc_in;
   logic                fail_ff, fail_in;
   logic [IDX_W-1:0]    base_ff, base_in;

   // Result register.
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic                rsp_alloc_ff, rsp_alloc_in;
   logic [TOTAL_W-1:0]  rsp_total_ff, rsp_total_in;
   logic [PGOUT_W-1:0]  rsp_pages_ff, rsp_pages_in;

   // Handshakes.
   logic req_go, cfg_go, mod_go;

   // Submodule connections.
   pbsa_pkg::div_res_type div_res;
   logic                find_found;
   logic [PAGE_W-1:0]   find_page;
   logic                mem_rd_en, mem_wr_en;
   logic [PAGE_W-1:0]   mem_rd_addr, mem_wr_addr;
   logic [BM_W-1:0]     mem_rd_data, mem_wr_data;

   // Page selection (read cycle).
   logic                is_alloc;
   logic                oor;
   logic                alloc_full;
   logic [PAGE_W+UPP_W-1:0] base_prod;

   // Update (modify cycle).
   logic [UPP_MAX-1:0]  mask_full;
   logic [BM_W-1:0]     mask;
   logic [LOC_W-1:0]    first_free;
   logic [LOC_W-1:0]    bitpos;
   logic [BM_W-1:0]     onehot;
   logic                bit_set;
   logic                beyond;
   logic [BM_W-1:0]     new_bm;
   logic                bm_wr;
   logic [TOTAL_W-1:0]  total_mod;
   logic [PCNT_W-1:0]   pc_mod;
   logic [STATUS_W-1:0] status_mod;
   logic [IDX_W-1:0]    slot_mod;
   logic                alloc_mod;

   // Register write value, clamped to 1..MAX_UNITS_PER_PAGE.
   logic [UPP_W-1:0]    cfg_upp;

   assign req_go     = req_tvalid && req_tready;
   assign cfg_go     = csr_valid && csr_ready;
   assign mod_go     = (state_ff == ST_MOD) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE) || (state_ff == ST_CLEAR);

   always_comb begin
      if (csr_data == '0) begin
         cfg_upp = UPP_W'(1);
      end else if (csr_data > UPP_W'(MAX_UNITS_PER_PAGE)) begin
         cfg_upp = UPP_W'(MAX_UNITS_PER_PAGE);
      end else begin
         cfg_upp = csr_data;
      end
   end

   // The divider and the page search run freely; both answers are registered
   // and ready by the read state of the sequencer.
   pbsa_recip_div u_div (
      .clock  (clock),
      .idx    (idx_ff),
      .upp    (upp_ff),
      .result (div_res)
   );

   pbsa_free_find #(
      .MAX_PAGES (MAX_PAGES)
   ) u_find (
      .clock      (clock),
      .full_vec   (full_ff),
      .page_count (page_count_ff),
      .found      (find_found),
      .page       (find_page)
   );

   pbsa_bitmap_mem #(
      .DEPTH (MAX_PAGES),
      .WIDTH (BM_W)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // Page selection. Allocation takes the first page that is not full, or
   // opens the page at the current count. Other requests use the page that
   // the divider split from the index.
   always_comb begin
      is_alloc   = (kind_ff == pbsa_pkg::KIND_ALLOC);
      oor        = (div_res.page >= IDX_W'(MAX_PAGES));
      alloc_full = !find_found && (page_count_ff == PCNT_W'(MAX_PAGES));
      if (is_alloc) begin
         mem_rd_addr = find_found ? find_page : page_count_ff[PAGE_W-1:0];
      end else begin
         mem_rd_addr = div_res.page[PAGE_W-1:0];
      end
      base_prod = (PAGE_W+UPP_W)'(mem_rd_addr) * (PAGE_W+UPP_W)'(upp_ff);
   end

   // Bitmap update. Pages at or above the page count, and pages whose count
   // has dropped to zero, always hold an all-zero bitmap, so the bitmap alone
   // tells whether a page is present.
   always_comb begin
      mask_full  = pbsa_pkg::upp_mask(upp_ff);
      mask       = mask_full[BM_W-1:0];
      first_free = '0;
      for (int i = BM_W - 1; i >= 0; i--) begin
         if (!mem_rd_data[i] && mask[i]) begin
            first_free = LOC_W'(i);
         end
      end
      bitpos  = is_alloc ? first_free : loc_ff;
      onehot  = BM_W'(1) << bitpos;
      bit_set = |(mem_rd_data & onehot);
      beyond  = (PCNT_W'(tgt_ff) >= page_count_ff);

      new_bm     = mem_rd_data;
      bm_wr      = 1'b0;
      total_mod  = total_ff;
      pc_mod     = page_count_ff;
      status_mod = pbsa_pkg::STATUS_OK;
      slot_mod   = idx_ff;
      alloc_mod  = 1'b0;

      if (fail_ff) begin
         // Pool full for allocation, or index past the last page.
         status_mod = pbsa_pkg::STATUS_FULL;
         slot_mod   = is_alloc ? '0 : idx_ff;
      end else begin
         case (kind_ff)
            pbsa_pkg::KIND_ALLOC, pbsa_pkg::KIND_OCCUPY: begin
               new_bm    = mem_rd_data | onehot;
               bm_wr     = 1'b1;
               alloc_mod = 1'b1;
               if (!bit_set) begin
                  total_mod = total_ff + TOTAL_W'(1);
               end
               if (beyond) begin
                  pc_mod = PCNT_W'(tgt_ff) + PCNT_W'(1);
               end
               if (is_alloc) begin
                  slot_mod = base_ff + IDX_W'(first_free);
               end
            end
            pbsa_pkg::KIND_FREE: begin
               if (beyond || (mem_rd_data == '0)) begin
                  status_mod = pbsa_pkg::STATUS_NOT_FOUND;
               end else begin
                  new_bm = mem_rd_data & ~onehot;
                  bm_wr  = 1'b1;
                  if (bit_set) begin
                     total_mod = total_ff - TOTAL_W'(1);
                  end
                  // An emptied last page shortens the page count by one.
                  if ((new_bm == '0) && (PCNT_W'(tgt_ff) + PCNT_W'(1) == page_count_ff)) begin
                     pc_mod = page_count_ff - PCNT_W'(1);
                  end
               end
            end
            pbsa_pkg::KIND_QUERY: begin
               alloc_mod = bit_set;
            end
            default: begin
               alloc_mod = 1'b0;
            end
         endcase
      end
   end

   // Sequencer and state update.
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      upp_in        = upp_ff;
      page_count_in = page_count_ff;
      total_in      = total_ff;
      full_in       = full_ff;
      kind_in       = kind_ff;
      idx_in        = idx_ff;
      tgt_in        = tgt_ff;
      loc_in        = loc_ff;
      fail_in       = fail_ff;
      base_in       = base_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_alloc_in  = rsp_alloc_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_pages_in  = rsp_pages_ff;
      mem_rd_en     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = tgt_ff;
      mem_wr_data   = new_bm;

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_ff;
            mem_wr_data = '0;
            if (clr_cnt_ff == PAGE_W'(MAX_PAGES - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + PAGE_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_go) begin
               kind_in  = req_tuser;
               idx_in   = req_tdata[IDX_W-1:0];
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_SEL;
         end
         ST_SEL: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            mem_rd_en = 1'b1;
            tgt_in    = mem_rd_addr;
            loc_in    = div_res.loc[LOC_W-1:0];
            fail_in   = is_alloc ? alloc_full : oor;
            base_in   = IDX_W'(base_prod);
            state_in  = ST_MOD;
         end
         ST_MOD: begin
            if (mod_go) begin
               mem_wr_en     = bm_wr;
               total_in      = total_mod;
               page_count_in = pc_mod;
               if (bm_wr) begin
                  full_in[tgt_ff] = (new_bm == mask);
               end
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_mod;
               rsp_slot_in   = slot_mod;
               rsp_alloc_in  = alloc_mod;
               rsp_total_in  = total_mod;
               rsp_pages_in  = PGOUT_W'(pc_mod);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A page size write counts only while no slot is in use; it also drops
      // any empty pages still counted.
      if (cfg_go && (total_ff == '0)) begin
         upp_in        = cfg_upp;
         page_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         upp_ff        <= UPP_W'(MAX_UNITS_PER_PAGE);
         page_count_ff <= '0;
         total_ff      <= '0;
         full_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         upp_ff        <= upp_in;
         page_count_ff <= page_count_in;
         total_ff      <= total_in;
         full_ff       <= full_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      idx_ff        <= idx_in;
      tgt_ff        <= tgt_in;
      loc_ff        <= loc_in;
      fail_ff       <= fail_in;
      base_ff       <= base_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_alloc_ff  <= rsp_alloc_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_pages_ff  <= rsp_pages_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_pages_ff, rsp_total_ff, rsp_alloc_ff, rsp_slot_ff};

   // A full page always holds at least one used slot.
   `PBSA_ASSERT_IMP(a_full_needs_use, clock, reset, total_ff == '0, full_ff == '0)
   // The page count never passes the number of pages.
   `PBSA_ASSERT_IMP(a_pc_bound, clock, reset, 1'b1, page_count_ff <= PCNT_W'(MAX_PAGES))
   // The memory is written only by the clearing sweep or a completing update.
   `PBSA_ASSERT_IMP(a_wr_source, clock, reset, mem_wr_en, (state_ff == ST_CLEAR) || mod_go)
   // A completed update always leaves a result waiting.
   `PBSA_ASSERT_NXT(a_mod_gives_rsp, clock, reset, mod_go, rsp_valid_ff)

endmodule

`default_nettype wire

// ----- rtl/core/pbsa_bitmap_mem.sv -----
// ----------------------------------------------------------------------------
// pbsa_bitmap_mem
// Single-port-write, single-port-read page bitmap memory, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbsa_bitmap_mem #(
   parameter  int DEPTH  = 64,
   parameter  int WIDTH  = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] bitmap_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= bitmap_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/pbsa_recip_div.sv -----
// ----------------------------------------------------------------------------
// pbsa_recip_div
// Two-stage slot index to page and offset split by reciprocal multiplication.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbsa_recip_div (
   input  logic                              clock,
   input  logic [pbsa_pkg::IDX_W-1:0]        idx,
   input  logic [pbsa_pkg::UPP_W-1:0]        upp,
   output pbsa_pkg::div_res_type             result
);

   localparam int IDX_W       = pbsa_pkg::IDX_W;
   localparam int UPP_W       = pbsa_pkg::UPP_W;
   localparam int QUO_W       = pbsa_pkg::QUO_W;
   localparam int RECIP_W     = pbsa_pkg::RECIP_W;
   localparam int RECIP_SHIFT = pbsa_pkg::RECIP_SHIFT;
   localparam int LOC_MAX_W   = pbsa_pkg::LOC_MAX_W;

   logic [IDX_W+RECIP_W-1:0] prod;
   logic [QUO_W-1:0]         quo_ff, quo_in;
   logic [IDX_W-1:0]         idx_ff;
   logic [UPP_W-1:0]         upp_ff;
   logic [QUO_W+UPP_W-1:0]   back;
   logic [IDX_W-1:0]         rem;
   pbsa_pkg::div_res_type    res_ff, res_in;

   // Stage one: quotient from the reciprocal table.
   always_comb begin
      prod   = (IDX_W+RECIP_W)'(idx) * (IDX_W+RECIP_W)'(pbsa_pkg::recip_of(upp));
      quo_in = prod[RECIP_SHIFT +: QUO_W];
   end

   // Stage two: remainder from the quotient.
   always_comb begin
      back          = (QUO_W+UPP_W)'(quo_ff) * (QUO_W+UPP_W)'(upp_ff);
      rem           = idx_ff - back[IDX_W-1:0];
      res_in.page   = quo_ff;
      res_in.loc    = rem[LOC_MAX_W-1:0];
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      idx_ff <= idx;
      upp_ff <= upp;
      res_ff <= res_in;
   end

   assign result = res_ff;

endmodule

`default_nettype wire

// ----- rtl/core/pbsa_free_find.sv -----
// ----------------------------------------------------------------------------
// pbsa_free_find
// Two-stage first-not-full page search below the current page count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbsa_free_find #(
   parameter  int MAX_PAGES = 64,
   localparam int PAGE_W    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1,
   localparam int PCNT_W    = $clog2(MAX_PAGES + 1)
) (
   input  logic                 clock,
   input  logic [MAX_PAGES-1:0] full_vec,
   input  logic [PCNT_W-1:0]    page_count,
   output logic                 found,
   output logic [PAGE_W-1:0]    page
);

   localparam int GRP    = 8;
   localparam int GRP_W  = 3;
   localparam int NGRP   = (MAX_PAGES + GRP - 1) / GRP;
   localparam int PAD_W  = NGRP * GRP;

   logic [MAX_PAGES-1:0] avail;
   logic [PAD_W-1:0]     avail_pad;
   logic [NGRP-1:0]      grp_any_ff, grp_any_in;
   logic [GRP_W-1:0]     grp_off_ff [NGRP];
   logic [GRP_W-1:0]     grp_off_in [NGRP];
   logic                 found_ff, found_in;
   logic [PAGE_W-1:0]    page_ff, page_in;

   // Stage one: per group of eight pages, any free page and the lowest one.
   always_comb begin
      for (int p = 0; p < MAX_PAGES; p++) begin
         avail[p] = !full_vec[p] && (PCNT_W'(p) < page_count);
      end
      avail_pad = PAD_W'(avail);
      for (int g = 0; g < NGRP; g++) begin
         grp_any_in[g] = 1'b0;
         grp_off_in[g] = '0;
         for (int k = GRP - 1; k >= 0; k--) begin
            if (avail_pad[g*GRP + k]) begin
               grp_any_in[g] = 1'b1;
               grp_off_in[g] = GRP_W'(k);
            end
         end
      end
   end

   // Stage two: lowest group that has a free page.
   always_comb begin
      found_in = 1'b0;
      page_in  = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            found_in = 1'b1;
            page_in  = PAGE_W'(g*GRP + int'(grp_off_ff[g]));
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_any_ff <= grp_any_in;
      grp_off_ff <= grp_off_in;
      found_ff   <= found_in;
      page_ff    <= page_in;
   end

   assign found = found_ff;
   assign page  = page_ff;

endmodule

`default_nettype wire

// ----- bench/pbsa_pool_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsa_pool_checker
// Watches the request, result and page size channels of the slot allocator,
// keeps its own copy of the page pool and compares every result with it.
// ----------------------------------------------------------------------------

module pbsa_pool_checker
   import pbsa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [5:0]  csr_data,
   output int          mismatches,
   output int          outstanding
);

   localparam int PAGES = 64;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    slot;
      logic                granted;
      logic [TOTAL_W-1:0]  total;
      logic [PGOUT_W-1:0]  pages;
   } pool_result_type;

   logic [UPP_MAX-1:0] bitmap [PAGES];
   int                 page_fill [PAGES];
   bit                 page_live [PAGES];
   int                 page_count;
   int                 slots_used;
   int                 page_size = UPP_MAX;
   pool_result_type    pool_results_q [$];
   pool_result_type    want;
   int                 fail_total = 0;

   function automatic bit slot_taken(input int page, input int loc);
      if (page >= PAGES || loc >= UPP_MAX) return 1'b0;
      if (!page_live[page]) return 1'b0;
      return bitmap[page][loc];
   endfunction

   task automatic clear_pool();
      for (int p = 0; p < PAGES; p++) begin
         bitmap[p]    = '0;
         page_fill[p] = 0;
         page_live[p] = 1'b0;
      end
      page_count = 0;
      slots_used = 0;
   endtask

   // Sets one slot; pages between the current end and the target are opened empty.
   task automatic take_slot(input int page, input int loc);
      if (page >= page_count) begin
         for (int p = page_count; p <= page; p++) begin
            bitmap[p]    = '0;
            page_fill[p] = 0;
            page_live[p] = 1'b0;
         end
         page_count = page + 1;
      end
      if (!page_live[page]) begin
         page_live[page] = 1'b1;
         bitmap[page]    = '0;
      end
      if (!bitmap[page][loc]) begin
         bitmap[page][loc] = 1'b1;
         page_fill[page]++;
         slots_used++;
      end
   endtask

   task automatic serve_request(input logic [1:0] kind, input int idx,
                                output pool_result_type res);
      int pg;
      int loc;
      int fp;
      int fl;
      bit found;
      pg          = idx / page_size;
      loc         = idx % page_size;
      fp          = 0;
      fl          = 0;
      found       = 1'b0;
      res.status  = STATUS_OK;
      res.slot    = '0;
      res.granted = 1'b0;
      if (kind == KIND_ALLOC) begin
         for (int p = 0; p < page_count && !found; p++) begin
            if (page_fill[p] != page_size) begin
               for (int u = 0; u < page_size && !found; u++) begin
                  if (!slot_taken(p, u)) begin
                     fp    = p;
                     fl    = u;
                     found = 1'b1;
                  end
               end
            end
         end
         if (!found && page_count < PAGES) begin
            fp    = page_count;
            fl    = 0;
            found = 1'b1;
         end
         if (found) begin
            take_slot(fp, fl);
            res.slot    = IDX_W'(fp * page_size + fl);
            res.granted = 1'b1;
         end else begin
            res.status = STATUS_FULL;
         end
      end else begin
         res.slot = IDX_W'(idx);
         if (pg >= PAGES) begin
            res.status = STATUS_FULL;
         end else if (kind == KIND_OCCUPY) begin
            take_slot(pg, loc);
            res.granted = 1'b1;
         end else if (kind == KIND_FREE) begin
            if (pg >= page_count || !page_live[pg]) begin
               res.status = STATUS_NOT_FOUND;
            end else if (page_fill[pg] != 0) begin
               if (bitmap[pg][loc]) begin
                  bitmap[pg][loc] = 1'b0;
                  page_fill[pg]--;
                  slots_used--;
               end
               // An emptied page is released; only the top page shrinks the count.
               if (page_fill[pg] == 0) begin
                  bitmap[pg]    = '0;
                  page_live[pg] = 1'b0;
                  if (pg + 1 == page_count) page_count--;
               end
            end
            res.granted = slot_taken(pg, loc);
         end else begin
            res.granted = (pg < page_count) && slot_taken(pg, loc);
         end
      end
      res.total = TOTAL_W'(slots_used);
      res.pages = PGOUT_W'(page_count);
   endtask

   task automatic check_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         fail_total++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_pool();
         page_size = UPP_MAX;
         pool_results_q.delete();
      end else begin
         // A new page size is taken only while no slot is in use.
         if (csr_valid && csr_ready && slots_used == 0) begin
            page_size  = (csr_data == 0) ? 1 : (csr_data > UPP_MAX) ? UPP_MAX : csr_data;
            page_count = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pool_results_q.size() == 0) begin
               $error("result with no request outstanding: tdata %h tuser %h",
                      rsp_tdata, rsp_tuser);
               fail_total++;
            end else begin
               want = pool_results_q.pop_front();
               check_field("status", want.status, rsp_tuser);
               check_field("slot_index", want.slot, rsp_tdata[10:0]);
               check_field("allocated", want.granted, rsp_tdata[11]);
               check_field("total_used", want.total, rsp_tdata[23:12]);
               check_field("pages_in_use", want.pages, rsp_tdata[30:24]);
            end
         end
         if (req_tvalid && req_tready) begin
            serve_request(req_tuser, int'(req_tdata[IDX_W-1:0]), want);
            pool_results_q.push_back(want);
         end
      end
      mismatches  <= fail_total;
      outstanding <= pool_results_q.size();
   end

endmodule

// ----- bench/paged_bitmap_slot_allocator_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_bitmap_slot_allocator_core_tb
// Drives allocate, occupy, free and query requests into the paged slot
// allocator under several page sizes, with random gaps and result stalls.
// A checker beside the block predicts every result; this module gives the verdict.
// ----------------------------------------------------------------------------

module paged_bitmap_slot_allocator_core_tb;

   import pbsa_pkg::*;

   // Cycles without any handshake before the run is declared hung.
   localparam int HANG_LIMIT = 3000;
   // Page sizes for the random phases; 0 and 63 are clamped by the block.
   localparam int SIZE_PLAN [10] = '{63, 0, 5, 32, 1, 17, 2, 31, 8, 12};
   localparam int PHASE_ITEMS = 165;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = KIND_QUERY;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [5:0]  csr_data   = '0;

   int mismatches;
   int outstanding;
   int idle_cycles = 0;
   // When set, neither side inserts gaps or stalls.
   bit no_idle = 1'b0;
   // Slots that the last result for them reported as set; used to empty the pool.
   bit slot_held [2048];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   paged_bitmap_slot_allocator_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   pbsa_pool_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   function automatic int pick_wait();
      return no_idle ? 0 : $urandom_range(0, 11);
   endfunction

   // Presents one request and returns right after the edge that accepts it.
   // Valid stays high into the next request when no gap is drawn.
   task automatic send(input logic [1:0] kind, input int idx);
      int gap;
      gap = pick_wait();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= kind;
      req_tdata  <= {5'b0, idx[IDX_W-1:0]};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops requesting and waits until every predicted result has arrived, then
   // lets the block settle back to idle.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_page_size(input logic [5:0] value);
      @(negedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Frees every slot still held so that a new page size is accepted.
   task automatic empty_pool();
      drain();
      for (int i = 0; i < 2048; i++) begin
         if (slot_held[i]) send(KIND_FREE, i);
      end
      drain();
   endtask

   task automatic random_phase(input int size_eff, input int count);
      int span;
      int hot_hi;
      int r;
      int idx;
      logic [1:0] kind;
      span   = 64 * size_eff;
      hot_hi = (span < 160) ? span - 1 : 159;
      for (int k = 0; k < count; k++) begin
         // Halfway through, hold off until the block has answered everything.
         if (k == count / 2) drain();
         r = $urandom_range(0, 99);
         if (r < 35)      kind = KIND_ALLOC;
         else if (r < 55) kind = KIND_OCCUPY;
         else if (r < 85) kind = KIND_FREE;
         else             kind = KIND_QUERY;
         r = $urandom_range(0, 99);
         if (r < 45)      idx = $urandom_range(0, hot_hi);
         else if (r < 85) idx = $urandom_range(0, span - 1);
         else             idx = $urandom_range(0, 2047);
         send(kind, idx);
      end
   endtask

   // The receiver draws a stall before each result and then waits for it.
   initial begin : rsp_side
      int stall;
      forever begin
         stall = pick_wait();
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && !reset));
         if (rsp_tuser == STATUS_OK) slot_held[rsp_tdata[IDX_W-1:0]] = rsp_tdata[11];
      end
   end

   // Watchdog: any accepted item, result or register write restarts the count.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= HANG_LIMIT) begin
         $display("paged_bitmap_slot_allocator_core_tb: errors");
         $finish;
      end
   end

   initial begin : stimulus
      int size_eff;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The register is writable during the clearing sweep after reset.
      write_page_size(6'd32);

      // Directed part at 32 slots per page.
      send(KIND_QUERY, 0);        // Query of a page that is not there.
      send(KIND_FREE, 5);         // Free with no pages open: not found.
      send(KIND_ALLOC, 2047);     // First allocation opens page 0, slot 0.
      send(KIND_ALLOC, 0);        // Next clear bit of the same page.
      send(KIND_OCCUPY, 2047);    // Highest index opens pages up to the last one.
      send(KIND_OCCUPY, 2047);    // Occupying a set slot must not count it twice.
      send(KIND_QUERY, 2047);
      send(KIND_FREE, 40);        // Gap page below the last page: not found.
      send(KIND_FREE, 3);         // Clear slot in a present page: no change.
      send(KIND_ALLOC, 0);        // First page not full gets slot 2.
      send(KIND_FREE, 2047);      // Last page empties and the page count drops.
      send(KIND_FREE, 1);
      send(KIND_FREE, 0);
      send(KIND_FREE, 2);         // Page 0 empties but is not the last page.
      send(KIND_ALLOC, 1023);     // Allocation lands in the released gap page.
      send(KIND_OCCUPY, 1234);
      send(KIND_QUERY, 1234);
      send(KIND_FREE, 1234);
      send(KIND_QUERY, 1500);

      // A page size write with slots in use must be ignored.
      drain();
      write_page_size(6'd4);
      send(KIND_ALLOC, 0);
      send(KIND_QUERY, 33);

      // Random phases, each under its own page size; small sizes also reach
      // a full pool and indexes beyond the last page.
      for (int ph = 0; ph < 10; ph++) begin
         empty_pool();
         write_page_size(6'(SIZE_PLAN[ph]));
         size_eff = (SIZE_PLAN[ph] == 0) ? 1 :
                    (SIZE_PLAN[ph] > UPP_MAX) ? UPP_MAX : SIZE_PLAN[ph];
         no_idle = (ph % 3 == 1);
         random_phase(size_eff, PHASE_ITEMS);
         no_idle = 1'b0;
      end

      drain();
      if (mismatches == 0 && outstanding == 0) begin
         $display("paged_bitmap_slot_allocator_core_tb: clean");
      end else begin
         $display("paged_bitmap_slot_allocator_core_tb: errors");
      end
      $finish;
   end

endmodule
